>>> sv/cbsd_pkg.sv
// Shared types and command codes for the command byte stream decoder.
`default_nettype none

package cbsd_pkg;

    // Command codes seen in the idle phase
    localparam logic [7:0] CMD_BUTTON = 8'd1;
    localparam logic [7:0] CMD_TEXT   = 8'd20;

    // Result kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_KEY   = 3'd1,
        PH_PRESS = 3'd2,
        PH_LEN   = 3'd3,
        PH_CHARS = 3'd4
    } phase_t;

endpackage

`default_nettype wire

>>> sv/command_byte_stream_decoder.sv
// Command byte stream decoder: input register, phase machine and result register.
//
// Usage:
//   Input channel data_valid/data_ready/data_byte carries one stream byte per
//   transfer. Output channel result_valid/result_ready carries key events
//   (result_kind 0: key_code, press_type) and console text characters
//   (result_kind 1: text_char, text_last).
//   Button command: 1, key code, press type -> one key event on the last byte.
//   Text command: 20, length, then length characters, each one a result;
//   a zero length ends the command on the length byte.
//   Other bytes while idle produce no result.
// Registers: a byte accepted on the input passes through two register stages,
//   the input register and then the result register.
// Throughput: one byte per cycle while the result slot is free or being taken.
// Reset: phase returns to idle, both register stages are emptied.
// Stall: while a result waits on result_ready, the byte in the input register
//   holds and data_ready drops once that register is full; bytes that give no
//   result also wait behind a pending result so ordering is kept simple.
`default_nettype none

module command_byte_stream_decoder
    import cbsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       data_valid,
    output logic            data_ready,
    input  wire logic [7:0] data_byte,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic            result_kind,
    output logic [7:0]      key_code,
    output logic [7:0]      press_type,
    output logic [7:0]      text_char,
    output logic            text_last
);

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // Decoder state
    phase_t     phase_reg, phase_next;
    logic [7:0] held_key_reg, held_key_next;
    logic [7:0] text_length_reg, text_length_next;
    logic [7:0] chars_received_reg, chars_received_next;

    // Result register
    logic       out_vld_reg;
    logic       kind_reg;
    logic [7:0] key_reg;
    logic [7:0] press_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    logic       emit;
    logic       emit_kind;
    logic [7:0] emit_key;
    logic [7:0] emit_press;
    logic [7:0] emit_char;
    logic       emit_last;
    logic [7:0] count_inc;

    logic out_free;
    logic advance;

    // Handshake: the held byte moves on when the result slot is free
    assign out_free   = !out_vld_reg || result_ready;
    assign advance    = in_vld_reg && out_free;
    assign data_ready = !in_vld_reg || advance;

    assign count_inc = chars_received_reg + 8'd1;

    // Next phase and result for the held byte
    always_comb
    begin
        phase_next          = phase_reg;
        held_key_next       = held_key_reg;
        text_length_next    = text_length_reg;
        chars_received_next = chars_received_reg;
        emit       = 1'b0;
        emit_kind  = KIND_KEY;
        emit_key   = 8'd0;
        emit_press = 8'd0;
        emit_char  = 8'd0;
        emit_last  = 1'b0;
        unique case (phase_reg)
            PH_KEY:
            begin
                held_key_next = in_byte_reg;
                phase_next    = PH_PRESS;
            end
            PH_PRESS:
            begin
                emit       = 1'b1;
                emit_kind  = KIND_KEY;
                emit_key   = held_key_reg;
                emit_press = in_byte_reg;
                phase_next = PH_IDLE;
            end
            PH_LEN:
            begin
                text_length_next    = in_byte_reg;
                chars_received_next = 8'd0;
                phase_next = (in_byte_reg == 8'd0) ? PH_IDLE : PH_CHARS;
            end
            PH_CHARS:
            begin
                chars_received_next = count_inc;
                emit      = 1'b1;
                emit_kind = KIND_TEXT;
                emit_char = in_byte_reg;
                if (count_inc == text_length_reg)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (in_byte_reg == CMD_BUTTON)
                    phase_next = PH_KEY;
                else if (in_byte_reg == CMD_TEXT)
                    phase_next = PH_LEN;
                else
                    phase_next = PH_IDLE;
            end
        endcase
    end

    // Input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (data_ready)
            in_vld_reg <= data_valid;
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
            in_byte_reg <= data_byte;
    end

    // Phase and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            held_key_reg       <= 8'd0;
            text_length_reg    <= 8'd0;
            chars_received_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            held_key_reg       <= held_key_next;
            text_length_reg    <= text_length_next;
            chars_received_reg <= chars_received_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= advance && emit;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg  <= emit_kind;
            key_reg   <= emit_key;
            press_reg <= emit_press;
            char_reg  <= emit_char;
            last_reg  <= emit_last;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_kind  = kind_reg;
    assign key_code     = key_reg;
    assign press_type   = press_reg;
    assign text_char    = char_reg;
    assign text_last    = last_reg;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the command byte stream decoder: directed and random streams.
`timescale 1ns / 1ps

module tb;
    import cbsd_pkg::*;

    // Exclusive upper bound of the range from which random one-byte codes are drawn
    localparam logic [7:0] CMD_LIMIT = 8'd24;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       kind;
        logic [7:0] key;
        logic [7:0] press;
        logic [7:0] ch;
        logic       last;
    } decoded_result_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       data_valid   = 1'b0;
    logic [7:0] data_byte    = 8'd0;
    logic       result_ready = 1'b0;
    logic       data_ready;
    logic       result_valid;
    logic       result_kind;
    logic [7:0] key_code;
    logic [7:0] press_type;
    logic [7:0] text_char;
    logic       text_last;

    // Predicted decoder state
    phase_t     pred_phase      = PH_IDLE;
    logic [7:0] pred_held_key   = 8'd0;
    logic [7:0] pred_text_len   = 8'd0;
    logic [7:0] pred_char_count = 8'd0;

    decoded_result_t pending_results[$];
    int error_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int rx_mode     = 0;

    command_byte_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .key_code     (key_code),
        .press_type   (press_type),
        .text_char    (text_char),
        .text_last    (text_last)
    );

    always #5 clk = ~clk;

    // Advance the predicted phase machine by one byte and queue any result
    task automatic decode_stream_byte(input logic [7:0] b);
        decoded_result_t r;
        r = '0;
        case (pred_phase)
            PH_KEY:
            begin
                pred_held_key = b;
                pred_phase    = PH_PRESS;
            end
            PH_PRESS:
            begin
                r.kind  = KIND_KEY;
                r.key   = pred_held_key;
                r.press = b;
                pending_results.push_back(r);
                pred_phase = PH_IDLE;
            end
            PH_LEN:
            begin
                pred_text_len   = b;
                pred_char_count = 8'd0;
                pred_phase      = (b == 8'd0) ? PH_IDLE : PH_CHARS;
            end
            PH_CHARS:
            begin
                pred_char_count = pred_char_count + 8'd1;
                r.kind = KIND_TEXT;
                r.ch   = b;
                r.last = (pred_char_count == pred_text_len);
                if (r.last)
                    pred_phase = PH_IDLE;
                pending_results.push_back(r);
            end
            default:
            begin
                if (b == CMD_BUTTON)
                    pred_phase = PH_KEY;
                else if (b == CMD_TEXT)
                    pred_phase = PH_LEN;
                else
                    pred_phase = PH_IDLE;
            end
        endcase
    endtask

    // One input transfer; the sender runs in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            data_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 12);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        decode_stream_byte(b);
        burst_left--;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        decoded_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expected transfer: kind %0d", result_kind);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", {7'd0, want.kind}, {7'd0, result_kind});
                check_field("key_code", want.key, key_code);
                check_field("press_type", want.press, press_type);
                check_field("text_char", want.ch, text_char);
                check_field("text_last", {7'd0, want.last}, {7'd0, text_last});
            end
        end
    end

    // Receiver stall pattern, chosen at random among four modes
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= (rx_cycle % 4 < 2);
            default: result_ready <= (rx_cycle % 16 == 0);
        endcase
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && data_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Key events with extreme key codes and press types
    task automatic test_button_extremes();
        send_byte(CMD_BUTTON);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(CMD_BUTTON);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    // Single-character and multi-character strings
    task automatic test_text_strings();
        send_byte(CMD_TEXT);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(CMD_TEXT);
        send_byte(8'd3);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
    endtask

    // Zero length ends the text command on the length byte
    task automatic test_zero_length_text();
        send_byte(CMD_TEXT);
        send_byte(8'd0);
        send_byte(CMD_BUTTON);
        send_byte(8'h5A);
        send_byte(8'hA5);
    endtask

    // Unknown one-byte commands and ignored codes
    task automatic test_ignored_codes();
        send_byte(8'd0);
        send_byte(CMD_LIMIT - 8'd1);
        send_byte(CMD_LIMIT);
        send_byte(8'hFF);
        send_byte(8'd2);
    endtask

    // Mostly well-formed commands with random content, some truncated, some noise
    task automatic test_random_stream();
        int made;
        int pick;
        int len;
        int n;
        logic [7:0] code;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_byte(CMD_BUTTON);
                send_byte(8'($urandom_range(0, 255)));
                made += 2;
                // occasionally drop the press type so the next byte takes its place
                if ($urandom_range(0, 19) != 0)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                    made++;
                end
            end
            else if (pick < 75)
            begin
                n = $urandom_range(0, 99);
                if (n < 5)
                    len = 0;
                else if (n < 7)
                    len = $urandom_range(100, 255);
                else
                    len = $urandom_range(1, 8);
                n = len;
                if (n > 0 && $urandom_range(0, 19) == 0)
                    n = $urandom_range(0, n - 1);
                send_byte(CMD_TEXT);
                send_byte(8'(len));
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                made += 2 + n;
            end
            else if (pick < 90)
            begin
                code = 8'($urandom_range(0, CMD_LIMIT - 1));
                while (code == CMD_BUTTON || code == CMD_TEXT)
                    code = 8'($urandom_range(0, CMD_LIMIT - 1));
                send_byte(code);
                made++;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_button_extremes();
        test_text_strings();
        test_zero_length_text();
        test_ignored_codes();
        test_random_stream();
        @(negedge clk);
        data_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
sv/cbsd_pkg.sv
sv/command_byte_stream_decoder.sv
dv/tb.sv
